FILE: hdl/acvv_pkg.sv
package acvv_pkg;

    localparam int SAMPLE_WIDTH  = 16;
    localparam int EST_FRAC_BITS = 16;
    localparam int EST_WIDTH     = 32;
    localparam int CFG_WIDTH     = 16;
    localparam int VEL_WIDTH     = 24;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;
    localparam int REG_IDX_W     = 1;

    localparam logic [CFG_WIDTH-1:0] ALPHA_RESET = 16'd655;
    localparam logic [CFG_WIDTH-1:0] SCALE_RESET = 16'd815;
    localparam logic [VEL_WIDTH-1:0] VEL_MAX     = '1;

    localparam logic [REG_IDX_W-1:0] REG_EMA_ALPHA      = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_VELOCITY_SCALE = 1'b1;

    localparam logic [1:0] LAST_AXIS = 2'd2;

    typedef enum logic [3:0] {
        OP_LOAD,
        OP_EMA_MUL,
        OP_EMA_UPD,
        OP_SQ_MUL,
        OP_SQ_ACC,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_SCALE_MUL,
        OP_OUT,
        OP_OUT_ZERO
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] axis;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

    // width of sample-minus-estimate differences
    function automatic int diff_width(input int sw, input int efb);
        return ((sw + efb > EST_WIDTH) ? sw + efb : EST_WIDTH) + 1;
    endfunction

    // width of the magnitude (square root of the summed squares)
    function automatic int root_width(input int sw, input int efb);
        return diff_width(sw, efb) - (efb - 8) + 1;
    endfunction

endpackage

FILE: hdl/acvv_ctrl.sv
module acvv_ctrl #(
    parameter int ROOT_WIDTH = acvv_pkg::root_width(acvv_pkg::SAMPLE_WIDTH,
                                                    acvv_pkg::EST_FRAC_BITS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_sample_valid,
    output logic              o_in_ready,
    input  acvv_pkg::t_status i_status,
    output acvv_pkg::t_cmd    o_cmd
);

    localparam int CW = $clog2(ROOT_WIDTH + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EMA_MUL,
        S_EMA_UPD,
        S_SQ_MUL,
        S_SQ_ACC,
        S_SQRT_INIT,
        S_SQRT_STEP,
        S_SCALE,
        S_FIN
    } t_state;

    t_state          r_state;
    acvv_pkg::t_cmd  r_cmd;
    logic [CW-1:0]   r_cnt;

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cmd.op   <= acvv_pkg::OP_LOAD;
            r_cmd.axis <= '0;
            r_cnt      <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd.axis <= '0;
                        if (i_sample_valid) begin
                            r_state  <= S_EMA_MUL;
                            r_cmd.op <= acvv_pkg::OP_EMA_MUL;
                        end else begin
                            r_state  <= S_FIN;
                            r_cmd.op <= acvv_pkg::OP_OUT_ZERO;
                        end
                    end
                end
                S_EMA_MUL: begin
                    r_state  <= S_EMA_UPD;
                    r_cmd.op <= acvv_pkg::OP_EMA_UPD;
                end
                S_EMA_UPD: begin
                    if (r_cmd.axis == acvv_pkg::LAST_AXIS) begin
                        r_state    <= S_SQ_MUL;
                        r_cmd.op   <= acvv_pkg::OP_SQ_MUL;
                        r_cmd.axis <= '0;
                    end else begin
                        r_state    <= S_EMA_MUL;
                        r_cmd.op   <= acvv_pkg::OP_EMA_MUL;
                        r_cmd.axis <= r_cmd.axis + 2'd1;
                    end
                end
                S_SQ_MUL: begin
                    r_state  <= S_SQ_ACC;
                    r_cmd.op <= acvv_pkg::OP_SQ_ACC;
                end
                S_SQ_ACC: begin
                    if (r_cmd.axis == acvv_pkg::LAST_AXIS) begin
                        r_state    <= S_SQRT_INIT;
                        r_cmd.op   <= acvv_pkg::OP_SQRT_INIT;
                        r_cmd.axis <= '0;
                    end else begin
                        r_state    <= S_SQ_MUL;
                        r_cmd.op   <= acvv_pkg::OP_SQ_MUL;
                        r_cmd.axis <= r_cmd.axis + 2'd1;
                    end
                end
                S_SQRT_INIT: begin
                    r_state  <= S_SQRT_STEP;
                    r_cmd.op <= acvv_pkg::OP_SQRT_STEP;
                    r_cnt    <= '0;
                end
                S_SQRT_STEP: begin
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(ROOT_WIDTH - 1)) begin
                        r_state  <= S_SCALE;
                        r_cmd.op <= acvv_pkg::OP_SCALE_MUL;
                    end
                end
                S_SCALE: begin
                    r_state  <= S_FIN;
                    r_cmd.op <= acvv_pkg::OP_OUT;
                end
                S_FIN: begin
                    // hold the output op until the result slot frees up
                    if (i_status.out_free) begin
                        r_state  <= S_IDLE;
                        r_cmd.op <= acvv_pkg::OP_LOAD;
                    end
                end
                default: begin
                    r_state  <= S_IDLE;
                    r_cmd.op <= acvv_pkg::OP_LOAD;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_valid_starts_ema: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid && i_sample_valid) |=>
        (r_cmd.op == acvv_pkg::OP_EMA_MUL && r_cmd.axis == '0))
        else $error("valid sample did not start EMA on first axis");

    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmd.axis <= acvv_pkg::LAST_AXIS)
        else $error("axis index out of range");

    a_fin_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && !i_status.out_free) |=>
        (r_state == S_FIN && $stable(r_cmd.op)))
        else $error("result dropped while output slot busy");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT_STEP) |-> (r_cnt < CW'(ROOT_WIDTH)))
        else $error("square root step count overrun");
`endif

endmodule

FILE: hdl/acvv_dp.sv
module acvv_dp #(
    parameter int SAMPLE_WIDTH           = acvv_pkg::SAMPLE_WIDTH,
    parameter int ESTIMATE_FRACTION_BITS = acvv_pkg::EST_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  acvv_pkg::t_cmd                    i_cmd,
    output acvv_pkg::t_status                 o_status,
    input  logic [acvv_pkg::CFG_WIDTH-1:0]    i_ema_alpha,
    input  logic [acvv_pkg::CFG_WIDTH-1:0]    i_velocity_scale,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_accel_x,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_accel_y,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_accel_z,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [acvv_pkg::VEL_WIDTH-1:0]    o_velocity,
    output logic                              o_reading_valid,
    output logic                              o_saturated
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int EFB  = ESTIMATE_FRACTION_BITS;
    localparam int EW   = acvv_pkg::EST_WIDTH;
    localparam int CFW  = acvv_pkg::CFG_WIDTH;
    localparam int VLW  = acvv_pkg::VEL_WIDTH;
    localparam int DW   = acvv_pkg::diff_width(SW, EFB);
    localparam int RW   = DW - (EFB - 8);
    localparam int MW   = acvv_pkg::root_width(SW, EFB);
    localparam int SUMW = 2 * MW;
    localparam int RMW  = MW + 2;
    localparam int MOW  = (DW > MW + 1) ? DW : MW + 1;
    localparam int PW   = 2 * MOW;
    localparam int SPW  = MW + CFW;
    localparam int VW   = SPW + 1 - CFW;
    localparam int VXW  = (VW > VLW + 1) ? VW : VLW + 1;

    localparam logic signed [DW:0] GMAX = {{(DW + 2 - EW){1'b0}}, {(EW - 1){1'b1}}};
    localparam logic signed [DW:0] GMIN = {{(DW + 2 - EW){1'b1}}, {(EW - 1){1'b0}}};
    localparam logic [SPW:0] ROUND_HALF = (SPW + 1)'(1) << (CFW - 1);

    logic signed [SW-1:0]  r_smp  [3];
    logic signed [EW-1:0]  r_est  [3];
    logic                  r_seeded;
    logic signed [RW-1:0]  r_res  [3];
    logic [SUMW-1:0]       r_sum;
    logic [SUMW-1:0]       r_nsh;
    logic [RMW-1:0]        r_rem;
    logic [MW-1:0]         r_root;
    logic signed [PW-1:0]  r_prod;
    logic                  r_out_valid;
    logic [VLW-1:0]        r_velocity;
    logic                  r_reading_valid;
    logic                  r_saturated;

    logic signed [DW-1:0]  w_scaled;
    logic signed [DW-1:0]  w_gold;
    logic signed [DW-1:0]  w_d;
    logic signed [PW-1:0]  w_psh;
    logic signed [DW:0]    w_gsum;
    logic signed [EW-1:0]  w_gnew;
    logic signed [DW-1:0]  w_rdiff;
    logic signed [DW-1:0]  w_rsh;
    logic signed [MOW-1:0] w_opa;
    logic signed [MOW-1:0] w_opb;
    logic [RMW-1:0]        w_rem_sh;
    logic [RMW-1:0]        w_trial;
    logic [SPW:0]          w_t;
    logic [VXW-1:0]        w_vx;
    logic                  w_sat;
    logic                  w_out_free;
    logic [1:0]            w_ax;

    assign w_ax = i_cmd.axis;

    // sample scaled to estimate units; the estimate seeds from it on first use
    assign w_scaled = DW'(r_smp[w_ax]) <<< EFB;
    assign w_gold   = r_seeded ? DW'(r_est[w_ax]) : w_scaled;
    assign w_d      = w_scaled - w_gold;
    assign w_psh    = r_prod >>> CFW;
    assign w_gsum   = (DW + 1)'(w_gold) + (DW + 1)'($signed(w_psh[DW-1:0]));

    always_comb begin
        if (w_gsum > GMAX) begin
            w_gnew = GMAX[EW-1:0];
        end else if (w_gsum < GMIN) begin
            w_gnew = GMIN[EW-1:0];
        end else begin
            w_gnew = w_gsum[EW-1:0];
        end
    end

    assign w_rdiff = w_scaled - DW'(w_gnew);
    assign w_rsh   = w_rdiff >>> (EFB - 8);

    always_comb begin
        case (i_cmd.op)
            acvv_pkg::OP_EMA_MUL: begin
                w_opa = MOW'(w_d);
                w_opb = MOW'(i_ema_alpha);
            end
            acvv_pkg::OP_SQ_MUL: begin
                w_opa = MOW'(r_res[w_ax]);
                w_opb = MOW'(r_res[w_ax]);
            end
            acvv_pkg::OP_SCALE_MUL: begin
                w_opa = MOW'(r_root);
                w_opb = MOW'(i_velocity_scale);
            end
            default: begin
                w_opa = '0;
                w_opb = '0;
            end
        endcase
    end

    // one result bit per step, two radicand bits shifted in
    assign w_rem_sh = {r_rem[RMW-3:0], r_nsh[SUMW-1 -: 2]};
    assign w_trial  = {r_root, 2'b01};

    assign w_t   = {1'b0, r_prod[SPW-1:0]} + ROUND_HALF;
    assign w_vx  = VXW'(w_t[SPW:CFW]);
    assign w_sat = (w_vx > VXW'(acvv_pkg::VEL_MAX));

    assign w_out_free        = !r_out_valid || i_out_ready;
    assign o_status.out_free = w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeded    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_est[i] <= '0;
            end
        end else begin
            if (i_cmd.op == acvv_pkg::OP_EMA_UPD) begin
                r_est[w_ax] <= w_gnew;
                if (w_ax == acvv_pkg::LAST_AXIS) begin
                    r_seeded <= 1'b1;
                end
            end
            if ((i_cmd.op == acvv_pkg::OP_OUT || i_cmd.op == acvv_pkg::OP_OUT_ZERO)
                    && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // scaled product stays put while the result waits for the output slot
        if (i_cmd.op != acvv_pkg::OP_OUT) begin
            r_prod <= w_opa * w_opb;
        end
        case (i_cmd.op)
            acvv_pkg::OP_LOAD: begin
                r_smp[0] <= i_accel_x;
                r_smp[1] <= i_accel_y;
                r_smp[2] <= i_accel_z;
            end
            acvv_pkg::OP_EMA_UPD: begin
                r_res[w_ax] <= w_rsh[RW-1:0];
            end
            acvv_pkg::OP_SQ_ACC: begin
                if (w_ax == '0) begin
                    r_sum <= r_prod[SUMW-1:0];
                end else begin
                    r_sum <= r_sum + r_prod[SUMW-1:0];
                end
            end
            acvv_pkg::OP_SQRT_INIT: begin
                r_nsh  <= r_sum;
                r_rem  <= '0;
                r_root <= '0;
            end
            acvv_pkg::OP_SQRT_STEP: begin
                r_nsh <= r_nsh << 2;
                if (w_rem_sh >= w_trial) begin
                    r_rem  <= w_rem_sh - w_trial;
                    r_root <= {r_root[MW-2:0], 1'b1};
                end else begin
                    r_rem  <= w_rem_sh;
                    r_root <= {r_root[MW-2:0], 1'b0};
                end
            end
            acvv_pkg::OP_OUT: begin
                if (w_out_free) begin
                    r_velocity      <= w_sat ? acvv_pkg::VEL_MAX : w_vx[VLW-1:0];
                    r_reading_valid <= 1'b1;
                    r_saturated     <= w_sat;
                end
            end
            acvv_pkg::OP_OUT_ZERO: begin
                if (w_out_free) begin
                    r_velocity      <= '0;
                    r_reading_valid <= 1'b0;
                    r_saturated     <= 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid     = r_out_valid;
    assign o_velocity      = r_velocity;
    assign o_reading_valid = r_reading_valid;
    assign o_saturated     = r_saturated;

`ifndef SYNTHESIS
    a_seed_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == acvv_pkg::OP_EMA_UPD && i_cmd.axis == acvv_pkg::LAST_AXIS)
        |=> r_seeded)
        else $error("estimates not marked seeded after update");

    a_result_posted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((i_cmd.op == acvv_pkg::OP_OUT || i_cmd.op == acvv_pkg::OP_OUT_ZERO)
         && w_out_free) |=> r_out_valid)
        else $error("result word not posted");

    a_sat_full_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_saturated) |-> (r_velocity == acvv_pkg::VEL_MAX
                                          && r_reading_valid))
        else $error("saturated word without full-scale velocity");
`endif

endmodule

FILE: hdl/ac_coupled_vibration_velocity.sv
// An accepted valid sample runs the EMA update and squaring per axis, then a square root
// over the magnitude width (26 bits at default parameters) one bit a cycle, then scaling,
// before its result word is posted; an invalid sample posts a zero word with no computation.
// Samples are taken one at a time: a new one only once the last word reaches the output slot.
// Reset (synchronous, active low) clears the gravity estimates and the seeded flag,
// empties the output slot and loads ema_alpha = 655, velocity_scale = 815.
module ac_coupled_vibration_velocity #(
    parameter int SAMPLE_WIDTH           = acvv_pkg::SAMPLE_WIDTH,
    parameter int ESTIMATE_FRACTION_BITS = acvv_pkg::EST_FRAC_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_accel_x,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_accel_y,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_accel_z,
    input  logic                            i_sample_valid,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [acvv_pkg::VEL_WIDTH-1:0]  o_velocity,
    output logic                            o_reading_valid,
    output logic                            o_saturated,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [acvv_pkg::APB_AW-1:0]     paddr,
    input  logic [acvv_pkg::APB_DW-1:0]     pwdata,
    output logic [acvv_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);

    localparam int MW = acvv_pkg::root_width(SAMPLE_WIDTH, ESTIMATE_FRACTION_BITS);

    logic [acvv_pkg::CFG_WIDTH-1:0] r_ema_alpha;
    logic [acvv_pkg::CFG_WIDTH-1:0] r_velocity_scale;
    logic [acvv_pkg::REG_IDX_W-1:0] w_idx;
    logic                           w_wr;
    acvv_pkg::t_cmd                 w_cmd;
    acvv_pkg::t_status              w_status;

    assign pready = 1'b1;
    assign w_idx  = paddr[2 +: acvv_pkg::REG_IDX_W];
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ema_alpha      <= acvv_pkg::ALPHA_RESET;
            r_velocity_scale <= acvv_pkg::SCALE_RESET;
        end else if (w_wr) begin
            case (w_idx)
                acvv_pkg::REG_EMA_ALPHA:      r_ema_alpha      <= pwdata[acvv_pkg::CFG_WIDTH-1:0];
                acvv_pkg::REG_VELOCITY_SCALE: r_velocity_scale <= pwdata[acvv_pkg::CFG_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            acvv_pkg::REG_EMA_ALPHA:      prdata = acvv_pkg::APB_DW'(r_ema_alpha);
            acvv_pkg::REG_VELOCITY_SCALE: prdata = acvv_pkg::APB_DW'(r_velocity_scale);
            default:                      prdata = '0;
        endcase
    end

    acvv_ctrl #(
        .ROOT_WIDTH (MW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_sample_valid (i_sample_valid),
        .o_in_ready     (o_ready),
        .i_status       (w_status),
        .o_cmd          (w_cmd)
    );

    acvv_dp #(
        .SAMPLE_WIDTH           (SAMPLE_WIDTH),
        .ESTIMATE_FRACTION_BITS (ESTIMATE_FRACTION_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_ema_alpha      (r_ema_alpha),
        .i_velocity_scale (r_velocity_scale),
        .i_accel_x        (i_accel_x),
        .i_accel_y        (i_accel_y),
        .i_accel_z        (i_accel_z),
        .i_out_ready      (i_ready),
        .o_out_valid      (o_valid),
        .o_velocity       (o_velocity),
        .o_reading_valid  (o_reading_valid),
        .o_saturated      (o_saturated)
    );

endmodule
